/* sv/encvel_pkg.sv */
// Shared constants, types and the microprogram of the encoder velocity estimator.
// Depends on nothing; every other file refers to it by scoped names.

package encvel_pkg;

  // scaling of the velocity result
  localparam int TICKS_PER_SECOND = 1000000;
  localparam int FRAC_BITS        = 8;

  localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
  localparam int MB_W    = (TPS_W > 17) ? TPS_W : 17;     // multiplier B operand
  localparam int PROD_W  = 32 + MB_W;
  localparam int NUM_W   = 32 + TPS_W + FRAC_BITS;         // dividend width
  localparam int HI_W    = NUM_W - 32;
  localparam int CMP_W   = (HI_W > 32) ? HI_W : 32;
  localparam int TERM_W  = 50;                             // signed filter term
  localparam int DIV_STEPS = 32;
  localparam int DIVC_W  = $clog2(DIV_STEPS);

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [15:0] DECAY_Q16 = 16'd64881;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  localparam logic CFG_ALPHA     = 1'b0;
  localparam logic CFG_MIN_TICKS = 1'b1;

  typedef logic [3:0] op_t;
  typedef logic [2:0] cond_t;
  typedef logic [3:0] step_t;

  // datapath operations
  localparam op_t OP_NOP       = 4'd0;
  localparam op_t OP_WAIT      = 4'd1;
  localparam op_t OP_EVAL      = 4'd2;
  localparam op_t OP_MUL_RATE  = 4'd3;
  localparam op_t OP_DIV_INIT  = 4'd4;
  localparam op_t OP_DIV_STEP  = 4'd5;
  localparam op_t OP_RATE_END  = 4'd6;
  localparam op_t OP_DECAY_MUL = 4'd7;
  localparam op_t OP_DECAY_END = 4'd8;
  localparam op_t OP_ZERO      = 4'd9;
  localparam op_t OP_FMUL1     = 4'd10;
  localparam op_t OP_FMUL2     = 4'd11;
  localparam op_t OP_FSUM      = 4'd12;
  localparam op_t OP_OUT       = 4'd13;

  // sequencer conditions
  localparam cond_t C_NEVER    = 3'd0;
  localparam cond_t C_ALWAYS   = 3'd1;
  localparam cond_t C_NO_INPUT = 3'd2;
  localparam cond_t C_ZERO     = 3'd3;
  localparam cond_t C_STILL    = 3'd4;
  localparam cond_t C_DIV_SAT  = 3'd5;
  localparam cond_t C_DIV_MORE = 3'd6;
  localparam cond_t C_OUT_BUSY = 3'd7;

  // program addresses
  localparam step_t S_WAIT      = 4'd0;
  localparam step_t S_EVAL      = 4'd1;
  localparam step_t S_CHK_ZERO  = 4'd2;
  localparam step_t S_CHK_STILL = 4'd3;
  localparam step_t S_MUL_RATE  = 4'd4;
  localparam step_t S_DIV_INIT  = 4'd5;
  localparam step_t S_DIV_STEP  = 4'd6;
  localparam step_t S_RATE_END  = 4'd7;
  localparam step_t S_DECAY_MUL = 4'd8;
  localparam step_t S_DECAY_END = 4'd9;
  localparam step_t S_ZERO      = 4'd10;
  localparam step_t S_FMUL1     = 4'd11;
  localparam step_t S_FMUL2     = 4'd12;
  localparam step_t S_FSUM      = 4'd13;
  localparam step_t S_OUT       = 4'd14;

  // hold: stay on the step while true; otherwise jump if jump is true, else advance
  typedef struct packed {
    op_t   op;
    cond_t hold;
    cond_t jump;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic zero_rate;
    logic still;
    logic div_sat;
    logic div_more;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    case (s)
      S_WAIT:      w = '{OP_WAIT,      C_NO_INPUT, C_NEVER,   S_WAIT};
      S_EVAL:      w = '{OP_EVAL,      C_NEVER,    C_NEVER,   S_WAIT};
      S_CHK_ZERO:  w = '{OP_NOP,       C_NEVER,    C_ZERO,    S_ZERO};
      S_CHK_STILL: w = '{OP_NOP,       C_NEVER,    C_STILL,   S_DECAY_MUL};
      S_MUL_RATE:  w = '{OP_MUL_RATE,  C_NEVER,    C_NEVER,   S_WAIT};
      S_DIV_INIT:  w = '{OP_DIV_INIT,  C_NEVER,    C_DIV_SAT, S_RATE_END};
      S_DIV_STEP:  w = '{OP_DIV_STEP,  C_DIV_MORE, C_NEVER,   S_WAIT};
      S_RATE_END:  w = '{OP_RATE_END,  C_NEVER,    C_ALWAYS,  S_FMUL1};
      S_DECAY_MUL: w = '{OP_DECAY_MUL, C_NEVER,    C_NEVER,   S_WAIT};
      S_DECAY_END: w = '{OP_DECAY_END, C_NEVER,    C_ALWAYS,  S_FMUL1};
      S_ZERO:      w = '{OP_ZERO,      C_NEVER,    C_NEVER,   S_WAIT};
      S_FMUL1:     w = '{OP_FMUL1,     C_NEVER,    C_NEVER,   S_WAIT};
      S_FMUL2:     w = '{OP_FMUL2,     C_NEVER,    C_NEVER,   S_WAIT};
      S_FSUM:      w = '{OP_FSUM,      C_NEVER,    C_NEVER,   S_WAIT};
      S_OUT:       w = '{OP_OUT,       C_OUT_BUSY, C_ALWAYS,  S_WAIT};
      default:     w = '{OP_NOP,       C_NEVER,    C_ALWAYS,  S_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* sv/encvel_sequencer.sv */
// Microprogram sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on encvel_pkg for the ROM, condition codes and the ctrl/status structs.

module encvel_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  encvel_pkg::status_t status,
  output encvel_pkg::ctrl_t   ctrl
);

  encvel_pkg::step_t  step_r, step_nxt;
  encvel_pkg::uword_t word;
  logic               hold_hit, jump_hit;

  function automatic logic cond_eval(input encvel_pkg::cond_t c,
                                     input encvel_pkg::status_t st);
    logic r;
    case (c)
      encvel_pkg::C_NEVER:    r = 1'b0;
      encvel_pkg::C_ALWAYS:   r = 1'b1;
      encvel_pkg::C_NO_INPUT: r = st.no_input;
      encvel_pkg::C_ZERO:     r = st.zero_rate;
      encvel_pkg::C_STILL:    r = st.still;
      encvel_pkg::C_DIV_SAT:  r = st.div_sat;
      encvel_pkg::C_DIV_MORE: r = st.div_more;
      encvel_pkg::C_OUT_BUSY: r = st.out_busy;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  assign word     = encvel_pkg::ucode_rom(step_r);
  assign hold_hit = cond_eval(word.hold, status);
  assign jump_hit = cond_eval(word.jump, status);
  assign ctrl.op  = word.op;

  always_comb begin
    if (hold_hit) begin
      step_nxt = step_r;
    end else if (jump_hit) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= encvel_pkg::S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* sv/encvel_datapath.sv */
// Datapath: input capture, motion classification, shared multiplier, serial divider,
// decay and alpha filter, output register. Driven by ctrl from encvel_sequencer.
// Depends on encvel_pkg for widths, constants and the ctrl/status structs.

module encvel_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  encvel_pkg::ctrl_t   ctrl,
  output encvel_pkg::status_t status,
  input  logic [16:0]         alpha,
  input  logic [15:0]         min_ticks,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_count,
  input  logic [31:0]         in_timestamp,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_filtered_velocity,
  output logic signed [31:0]  out_raw_velocity,
  output logic [1:0]          out_direction
);

  localparam int PW = encvel_pkg::PROD_W;
  localparam int TW = encvel_pkg::TERM_W;

  // captured word
  logic [31:0] cnt_r, ts_r;
  logic        restart_r;

  // persistent state
  logic        started_r;
  logic [31:0] last_count_r, last_time_r;
  logic [1:0]  last_dir_r;
  logic [31:0] raw_r, filt_r;

  // per-word working registers
  logic        moved_r, zero_r, neg_r;
  logic [31:0] mag_r, elapsed_r;
  logic [PW-1:0] prod_r;
  logic [31:0] rem_r, qn_r;
  logic [encvel_pkg::DIVC_W-1:0] divc_r;
  logic [TW-1:0] term_r;

  logic        out_valid_r;
  logic [31:0] out_filt_r, out_raw_r;
  logic [1:0]  out_dir_r;

  logic        accept, out_busy, out_load;

  // classification
  logic        fresh, moved, turned, small_gap;
  logic [31:0] base_cnt, base_time, elapsed;
  logic [1:0]  base_dir, new_dir;
  logic [32:0] diff;

  // multiplier
  logic [31:0]          mul_a;
  logic [encvel_pkg::MB_W-1:0] mul_b;
  logic [PW-1:0]        prod_nxt;
  logic [16:0]          a_eff, w1;
  logic [31:0]          abs_raw, abs_filt;

  // divider
  logic [encvel_pkg::NUM_W-1:0] num;
  logic [encvel_pkg::HI_W-1:0]  num_hi;
  logic        div_sat;
  logic [32:0] trial;
  logic        ge;

  // filter
  logic [TW-1:0] term_nxt, sum;
  logic [TW-1:0] sum_mag, sum_rnd;
  logic [31:0]   fmag;
  logic [31:0]   dmag;

  assign in_stall = !rst_n || (ctrl.op != encvel_pkg::OP_WAIT);
  assign accept   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign out_load = (ctrl.op == encvel_pkg::OP_OUT) && !out_busy;

  // --- classification of the captured sample
  assign fresh     = restart_r || !started_r;
  assign base_cnt  = fresh ? cnt_r : last_count_r;
  assign base_time = fresh ? ts_r : last_time_r;
  assign base_dir  = fresh ? encvel_pkg::DIR_NONE : last_dir_r;
  assign diff      = {cnt_r[31], cnt_r} - {base_cnt[31], base_cnt};
  assign moved     = (diff != 33'd0);
  assign new_dir   = diff[32] ? encvel_pkg::DIR_BACK : encvel_pkg::DIR_FWD;
  assign turned    = moved && (base_dir != new_dir);
  assign elapsed   = ts_r - base_time;
  assign small_gap = (elapsed == 32'd0) || (elapsed < {16'd0, min_ticks});

  // --- shared multiplier
  assign a_eff    = alpha[16] ? encvel_pkg::ONE_Q16 : alpha;   // weights above one clamp
  assign w1       = encvel_pkg::ONE_Q16 - a_eff;
  assign abs_raw  = raw_r[31] ? (~raw_r + 32'd1) : raw_r;
  assign abs_filt = filt_r[31] ? (~filt_r + 32'd1) : filt_r;

  always_comb begin
    case (ctrl.op)
      encvel_pkg::OP_MUL_RATE: begin
        mul_a = mag_r;
        mul_b = encvel_pkg::MB_W'(encvel_pkg::TICKS_PER_SECOND);
      end
      encvel_pkg::OP_DECAY_MUL: begin
        mul_a = abs_raw;
        mul_b = encvel_pkg::MB_W'(encvel_pkg::DECAY_Q16);
      end
      encvel_pkg::OP_FMUL1: begin
        mul_a = abs_raw;
        mul_b = encvel_pkg::MB_W'(w1);
      end
      default: begin
        mul_a = abs_filt;
        mul_b = encvel_pkg::MB_W'(a_eff);
      end
    endcase
  end

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  // --- divider: quotient of num by elapsed, saturating when it needs more than 32 bits
  assign num     = encvel_pkg::NUM_W'(prod_r[31+encvel_pkg::TPS_W:0]) << encvel_pkg::FRAC_BITS;
  assign num_hi  = num[encvel_pkg::NUM_W-1:32];
  assign div_sat = (encvel_pkg::CMP_W'(num_hi) >= encvel_pkg::CMP_W'(elapsed_r));
  assign trial   = {rem_r, qn_r[31]};
  assign ge      = (trial >= {1'b0, elapsed_r});

  // --- filter terms, signed
  assign term_nxt = filt_r[31] ? (TW'(0) - TW'(prod_r[48:0])) : TW'(prod_r[48:0]);
  assign sum      = term_r + term_nxt;
  assign sum_mag  = sum[TW-1] ? (TW'(0) - sum) : sum;
  assign sum_rnd  = sum_mag + TW'(32768);
  assign fmag     = sum_rnd[47:16];
  assign dmag     = prod_r[47:16];

  assign status.no_input  = !in_valid;
  assign status.zero_rate = zero_r;
  assign status.still     = !moved_r;
  assign status.div_sat   = div_sat;
  assign status.div_more  = (divc_r != encvel_pkg::DIVC_W'(encvel_pkg::DIV_STEPS - 1));
  assign status.out_busy  = out_busy;

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r     <= in_count;
      ts_r      <= in_timestamp;
      restart_r <= in_restart;
    end
    if (ctrl.op == encvel_pkg::OP_EVAL) begin
      moved_r   <= moved;
      zero_r    <= turned || (moved && small_gap);
      neg_r     <= diff[32];
      mag_r     <= diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
      elapsed_r <= elapsed;
      if (moved || fresh) begin
        last_count_r <= cnt_r;
        last_time_r  <= ts_r;
      end
    end
    case (ctrl.op)
      encvel_pkg::OP_MUL_RATE,
      encvel_pkg::OP_DECAY_MUL,
      encvel_pkg::OP_FMUL1,
      encvel_pkg::OP_FMUL2: prod_r <= prod_nxt;
      default: ;
    endcase
    if (ctrl.op == encvel_pkg::OP_FMUL2) begin
      // first term carries the sign of the raw velocity
      term_r <= raw_r[31] ? (TW'(0) - TW'(prod_r[48:0])) : TW'(prod_r[48:0]);
    end
    if (ctrl.op == encvel_pkg::OP_DIV_INIT) begin
      divc_r <= '0;
      if (div_sat) begin
        qn_r <= '1;
      end else begin
        rem_r <= 32'(num_hi);
        qn_r  <= num[31:0];
      end
    end
    if (ctrl.op == encvel_pkg::OP_DIV_STEP) begin
      divc_r <= divc_r + 1'b1;
      rem_r  <= ge ? 32'(trial - {1'b0, elapsed_r}) : trial[31:0];
      qn_r   <= {qn_r[30:0], ge};
    end
    if (out_load) begin
      out_filt_r <= filt_r;
      out_raw_r  <= raw_r;
      out_dir_r  <= last_dir_r;
    end
  end

  // control state and filter memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      last_dir_r  <= encvel_pkg::DIR_NONE;
      raw_r       <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (ctrl.op)
        encvel_pkg::OP_EVAL: begin
          started_r  <= 1'b1;
          last_dir_r <= moved ? new_dir : base_dir;
        end
        encvel_pkg::OP_RATE_END: begin
          if (neg_r) begin
            raw_r <= (qn_r > 32'h8000_0000) ? 32'h8000_0000 : (~qn_r + 32'd1);
          end else begin
            raw_r <= qn_r[31] ? 32'h7FFF_FFFF : qn_r;
          end
        end
        encvel_pkg::OP_DECAY_END: raw_r <= raw_r[31] ? (~dmag + 32'd1) : dmag;
        encvel_pkg::OP_ZERO:      raw_r <= '0;
        encvel_pkg::OP_FSUM:      filt_r <= sum[TW-1] ? (~fmag + 32'd1) : fmag;
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_filtered_velocity = out_filt_r;
  assign out_raw_velocity      = out_raw_r;
  assign out_direction         = out_dir_r;

endmodule

/* sv/encoder_velocity_estimator_unit.sv */
// Top level of the encoder velocity estimator: configuration registers,
// microprogram sequencer and datapath. Depends on encvel_pkg, encvel_sequencer
// and encvel_datapath.
//
//  channel  dir  handshake            payload
//  in       in   in_valid / in_stall  in_count, in_timestamp, in_restart
//  out      out  out_valid/out_stall  out_filtered_velocity, out_raw_velocity,
//                                     out_direction
//  cfg      in   cfg_wr_en            cfg_index, cfg_wdata (0 alpha, 1 min_ticks)
//
// One word at a time: when the count moved the same way the 32-step serial divider
// dominates; a saturating quotient skips its steps, and the decay path and forcing
// raw to zero skip it too. out_valid rises as the program returns to its wait step,
// and the next word can be taken from there.
// rst_n is synchronous; it clears state, sets alpha 0, min_ticks 1 and holds in_stall.
// in_stall is low only while the sequencer waits for a word; a result waits in the
// output register while the next word is taken, and the program holds its last
// step while out_stall keeps that register full.

module encoder_velocity_estimator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_count,
  input  logic [31:0]        in_timestamp,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_filtered_velocity,
  output logic signed [31:0] out_raw_velocity,
  output logic [1:0]         out_direction,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_wdata
);

  logic [16:0] alpha_r;
  logic [15:0] min_ticks_r;

  encvel_pkg::ctrl_t   ctrl;
  encvel_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= '0;
      min_ticks_r <= 16'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        encvel_pkg::CFG_ALPHA:     alpha_r     <= cfg_wdata;
        encvel_pkg::CFG_MIN_TICKS: min_ticks_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  encvel_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  encvel_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctrl                  (ctrl),
    .status                (status),
    .alpha                 (alpha_r),
    .min_ticks             (min_ticks_r),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_count              (in_count),
    .in_timestamp          (in_timestamp),
    .in_restart            (in_restart),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_filtered_velocity (out_filtered_velocity),
    .out_raw_velocity      (out_raw_velocity),
    .out_direction         (out_direction)
  );

endmodule
